### hdl/pftp_pkg.sv
`timescale 1ns / 1ps

package pftp_pkg;

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned NrmW    = 16;
  localparam int unsigned OffW    = 17;
  localparam int unsigned InDataW = 9 * CoordW;
  localparam int unsigned OutDataW = 72;

  // Internal widths
  localparam int unsigned EdgeW = 17;   // point differences
  localparam int unsigned SumW  = 18;   // a + b + c per axis
  localparam int unsigned PrdW  = 34;   // 17 x 17 products
  localparam int unsigned CrsW  = 35;   // cross product components
  localparam int unsigned DstW  = 36;   // squared edge lengths
  localparam int unsigned MagW  = 34;   // magnitudes before scaling
  localparam int unsigned PosW  = 6;    // leading one position
  localparam int unsigned NrmTop = 29;  // scaled magnitude lies in [2^29, 2^30)
  localparam int unsigned MW    = 30;   // scaled magnitudes
  localparam int unsigned SqW   = 60;
  localparam int unsigned SW    = 62;   // sum of squares
  localparam int unsigned LW    = 31;   // vector length
  localparam int unsigned NumW  = 45;   // dividend m * 2^14 + L / 2
  localparam int unsigned QW    = 15;   // quotient bits
  localparam int unsigned DotW  = 36;
  localparam int unsigned TW    = 20;   // rounded offset before divide by three
  localparam int unsigned QqW   = 19;

  localparam logic [QW-1:0]  OneQ14     = QW'(16384);
  localparam logic [DotW-1:0] OffHalf   = DotW'(24576);
  localparam logic [TW:0]    Recip3     = 21'd699051;  // ceil(2^21 / 3)
  localparam logic [QqW-1:0] OffPosMax  = QqW'(65535);
  localparam logic [QqW-1:0] OffNegMax  = QqW'(65536);

  // Pipeline stage map
  localparam int unsigned StDiff = 0;
  localparam int unsigned StMul  = 1;
  localparam int unsigned StNsum = 2;
  localparam int unsigned StPick = 3;
  localparam int unsigned StSel  = 4;
  localparam int unsigned StLz   = 5;
  localparam int unsigned StShf  = 6;
  localparam int unsigned StSqr  = 7;
  localparam int unsigned StSsum = 8;
  localparam int unsigned StRt0  = 9;
  localparam int unsigned RtSteps = LW;
  localparam int unsigned StNum  = StRt0 + RtSteps;
  localparam int unsigned StDv0  = StNum + 1;
  localparam int unsigned DvSteps = QW;
  localparam int unsigned StQnt  = StDv0 + DvSteps;
  localparam int unsigned StDotm = StQnt + 1;
  localparam int unsigned StDots = StQnt + 2;
  localparam int unsigned StRnd  = StQnt + 3;
  localparam int unsigned StDiv3 = StQnt + 4;
  localparam int unsigned StOut  = StQnt + 5;
  localparam int unsigned NSt    = StOut + 1;

  // Side data that rides along the whole pipeline
  typedef struct packed {
    logic [2:0][SumW-1:0] sum;
    logic                 deg;
    logic                 zedge;
    logic [2:0]           sgn;
    logic [2:0][NrmW-1:0] nrm;
  } carry_t;

endpackage

### hdl/plane_from_three_points.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z (16 bits each)
// m_axis    out  tdata: normal_x normal_y normal_z offset; tuser: degenerate
//
// One beat in per cycle unless a full pipeline is stalled, one beat out per item;
// 62 register stages lie between an input beat and its output beat.
// The length is set by the square root (31 stages, one result bit each) and
// the normalizing divide (15 stages, one quotient bit each).
// Reset clears only the stage valid bits. Each stage holds while the stage
// after it is full and stalled; empty stages fill, so bubbles close up.
module plane_from_three_points (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  logic [pftp_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // normal_x, normal_y, normal_z, offset, zero pad from bit 0 up
  output logic [pftp_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // degenerate
  output logic                             m_axis_tuser_o
);

  import pftp_pkg::*;

  // Stage handshake
  logic [NSt-1:0] vld_q, vld_d, en;
  carry_t         carry_q [NSt];
  carry_t         carry_d [NSt];

  always_comb begin
    en[NSt-1] = !vld_q[NSt-1] || m_axis_tready_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = s_axis_tvalid_i;
    for (int k = 1; k < NSt; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 0: edges and per-axis sums
  logic signed [EdgeW-1:0] u0_d [3], w0_d [3], e0_d [3];
  logic signed [EdgeW-1:0] u0_q [3], w0_q [3], e0_q [3];
  logic [2:0][SumW-1:0]    sum0;

  always_comb begin
    logic [CoordW-1:0] pa, pb, pc;
    for (int i = 0; i < 3; i++) begin
      pa = s_axis_tdata_i[CoordW*i +: CoordW];
      pb = s_axis_tdata_i[CoordW*(3+i) +: CoordW];
      pc = s_axis_tdata_i[CoordW*(6+i) +: CoordW];
      u0_d[i] = {pb[CoordW-1], pb} - {pa[CoordW-1], pa};
      w0_d[i] = {pc[CoordW-1], pc} - {pa[CoordW-1], pa};
      e0_d[i] = {pb[CoordW-1], pb} - {pc[CoordW-1], pc};
      sum0[i] = {{2{pa[CoordW-1]}}, pa} + {{2{pb[CoordW-1]}}, pb}
              + {{2{pc[CoordW-1]}}, pc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StDiff]) begin
      u0_q <= u0_d;
      w0_q <= w0_d;
      e0_q <= e0_d;
    end
  end

  // Stage 1: cross product terms and squared edge components
  logic signed [PrdW-1:0]  pc1_d [6], pc1_q [6];
  logic [PrdW-1:0]         sq1_d [9], sq1_q [9];
  logic signed [EdgeW-1:0] u1_q [3], w1_q [3], e1_q [3];

  always_comb begin
    logic signed [PrdW-1:0] t;
    pc1_d[0] = u0_q[1] * w0_q[2];
    pc1_d[1] = u0_q[2] * w0_q[1];
    pc1_d[2] = u0_q[2] * w0_q[0];
    pc1_d[3] = u0_q[0] * w0_q[2];
    pc1_d[4] = u0_q[0] * w0_q[1];
    pc1_d[5] = u0_q[1] * w0_q[0];
    for (int i = 0; i < 3; i++) begin
      t = u0_q[i] * u0_q[i];
      sq1_d[i] = t;
      t = e0_q[i] * e0_q[i];
      sq1_d[3+i] = t;
      t = w0_q[i] * w0_q[i];
      sq1_d[6+i] = t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StMul]) begin
      pc1_q <= pc1_d;
      sq1_q <= sq1_d;
      u1_q  <= u0_q;
      w1_q  <= w0_q;
      e1_q  <= e0_q;
    end
  end

  // Stage 2: raw normal and squared edge lengths
  logic signed [CrsW-1:0]  n2_d [3], n2_q [3];
  logic [DstW-1:0]         d2_d [3], d2_q [3];
  logic signed [EdgeW-1:0] u2_q [3], w2_q [3], e2_q [3];

  always_comb begin
    n2_d[0] = pc1_q[0] - pc1_q[1];
    n2_d[1] = pc1_q[2] - pc1_q[3];
    n2_d[2] = pc1_q[4] - pc1_q[5];
    for (int i = 0; i < 3; i++) begin
      d2_d[i] = DstW'(sq1_q[3*i]) + DstW'(sq1_q[3*i+1]) + DstW'(sq1_q[3*i+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StNsum]) begin
      n2_q <= n2_d;
      d2_q <= d2_d;
      u2_q <= u1_q;
      w2_q <= w1_q;
      e2_q <= e1_q;
    end
  end

  // Stage 3: collinear test and longest edge pick (ties keep earlier edge)
  logic signed [CrsW-1:0]  n3_q [3];
  logic signed [EdgeW-1:0] e3_d [3], e3_q [3];
  logic                    zero3;

  always_comb begin
    zero3 = (n2_q[0] == '0) && (n2_q[1] == '0) && (n2_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      if (d2_q[0] >= d2_q[1]) begin
        e3_d[i] = (d2_q[0] >= d2_q[2]) ? -u2_q[i] : w2_q[i];
      end else begin
        e3_d[i] = (d2_q[1] >= d2_q[2]) ? e2_q[i] : w2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StPick]) begin
      n3_q <= n2_q;
      e3_q <= e3_d;
    end
  end

  // Stage 4: choose the vector to scale, split sign and magnitude
  logic [MagW-1:0] m4_d [3], m4_q [3];
  logic [2:0]      sgn4;
  logic            zedge4;

  always_comb begin
    logic signed [CrsW-1:0] p [3];
    logic signed [CrsW-1:0] ex, ey, ez, nx, ny, nz;
    logic [EdgeW-1:0]       ax, ay, az;
    logic signed [CrsW-1:0] pn;
    ex = CrsW'(e3_q[0]);
    ey = CrsW'(e3_q[1]);
    ez = CrsW'(e3_q[2]);
    nx = -ex;
    ny = -ey;
    nz = -ez;
    ax = e3_q[0][EdgeW-1] ? -e3_q[0] : e3_q[0];
    ay = e3_q[1][EdgeW-1] ? -e3_q[1] : e3_q[1];
    az = e3_q[2][EdgeW-1] ? -e3_q[2] : e3_q[2];
    zedge4 = 1'b0;
    if (!carry_q[StPick].deg) begin
      p[0] = n3_q[0];
      p[1] = n3_q[1];
      p[2] = n3_q[2];
    end else if (ax >= ay && ax >= az) begin
      zedge4 = (ax == '0);
      p[0] = ny;
      p[1] = ex;
      p[2] = '0;
    end else if (ay >= az) begin
      p[0] = '0;
      p[1] = nz;
      p[2] = ey;
    end else begin
      p[0] = ez;
      p[1] = '0;
      p[2] = nx;
    end
    for (int i = 0; i < 3; i++) begin
      sgn4[i] = p[i][CrsW-1];
      pn = p[i][CrsW-1] ? -p[i] : p[i];
      m4_d[i] = pn[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StSel]) begin
      m4_q <= m4_d;
    end
  end

  // Stage 5: leading one of the largest magnitude
  logic [MagW-1:0] m5_q [3];
  logic [PosW-1:0] pos5_d, pos5_q;

  always_comb begin
    logic [MagW-1:0] orv;
    orv = m4_q[0] | m4_q[1] | m4_q[2];
    pos5_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) pos5_d = PosW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StLz]) begin
      m5_q   <= m4_q;
      pos5_q <= pos5_d;
    end
  end

  // Stage 6: scale so the largest magnitude lands in [2^29, 2^30)
  logic [MW-1:0] m6_d [3], m6_q [3];

  always_comb begin
    logic [MagW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (pos5_q >= PosW'(NrmTop)) begin
        sh = m5_q[i] >> (pos5_q - PosW'(NrmTop));
      end else begin
        sh = m5_q[i] << (PosW'(NrmTop) - pos5_q);
      end
      m6_d[i] = sh[MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StShf]) begin
      m6_q <= m6_d;
    end
  end

  // Stage 7: squares
  logic [SqW-1:0] sq7_d [3], sq7_q [3];
  logic [MW-1:0]  m7_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq7_d[i] = m6_q[i] * m6_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StSqr]) begin
      sq7_q <= sq7_d;
      m7_q  <= m6_q;
    end
  end

  // Stage 8: sum of squares
  logic [SW-1:0] s8_q;
  logic [MW-1:0] m8_q [3];

  always_ff @(posedge clk_i) begin
    if (en[StSsum]) begin
      s8_q <= SW'(sq7_q[0]) + SW'(sq7_q[1]) + SW'(sq7_q[2]);
      m8_q <= m7_q;
    end
  end

  // Square root: one result bit per stage
  logic [SW-1:0] rv_q [RtSteps];
  logic [SW-1:0] rr_q [RtSteps];
  logic [MW-1:0] rm_q [RtSteps][3];

  for (genvar j = 0; j < RtSteps; j++) begin : g_rt
    localparam logic [SW-1:0] RtBit = SW'(1) << (2 * (RtSteps - 1 - j));
    logic [SW-1:0] v_in, r_in, t, rv_d, rr_d;
    logic [MW-1:0] m_in [3];

    if (j == 0) begin : g_first
      assign v_in = s8_q;
      assign r_in = '0;
      assign m_in = m8_q;
    end else begin : g_next
      assign v_in = rv_q[j-1];
      assign r_in = rr_q[j-1];
      assign m_in = rm_q[j-1];
    end

    always_comb begin
      t = r_in + RtBit;
      if (v_in >= t) begin
        rv_d = v_in - t;
        rr_d = (r_in >> 1) + RtBit;
      end else begin
        rv_d = v_in;
        rr_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StRt0 + j]) begin
        rv_q[j] <= rv_d;
        rr_q[j] <= rr_d;
        rm_q[j] <= m_in;
      end
    end
  end

  // Dividends with half the length added for rounding
  logic [NumW-1:0] num_d [3], num_q [3];
  logic [LW-1:0]   len_q;
  logic [LW-1:0]   len_d;

  always_comb begin
    len_d = rr_q[RtSteps-1][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NumW'(rm_q[RtSteps-1][i]) << 14) + NumW'(len_d >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StNum]) begin
      num_q <= num_d;
      len_q <= len_d;
    end
  end

  // Restoring divide: one quotient bit per stage, three lanes
  logic [NumW-1:0] dr_q [DvSteps][3];
  logic [QW-1:0]   dq_q [DvSteps][3];
  logic [LW-1:0]   dl_q [DvSteps];

  for (genvar j = 0; j < DvSteps; j++) begin : g_dv
    localparam int unsigned Kb = DvSteps - 1 - j;
    logic [NumW-1:0] r_in [3];
    logic [QW-1:0]   q_in [3];
    logic [LW-1:0]   l_in;
    logic [NumW-1:0] r_d [3];
    logic [QW-1:0]   q_d [3];

    if (j == 0) begin : g_first
      assign r_in = num_q;
      assign l_in = len_q;
      always_comb begin
        for (int i = 0; i < 3; i++) q_in[i] = '0;
      end
    end else begin : g_next
      assign r_in = dr_q[j-1];
      assign q_in = dq_q[j-1];
      assign l_in = dl_q[j-1];
    end

    always_comb begin
      logic [NumW:0] dsh;
      dsh = (NumW+1)'(l_in) << Kb;
      for (int i = 0; i < 3; i++) begin
        q_d[i] = q_in[i];
        if ({1'b0, r_in[i]} >= dsh) begin
          r_d[i] = r_in[i] - dsh[NumW-1:0];
          q_d[i][Kb] = 1'b1;
        end else begin
          r_d[i] = r_in[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StDv0 + j]) begin
        dr_q[j] <= r_d;
        dq_q[j] <= q_d;
        dl_q[j] <= l_in;
      end
    end
  end

  // Clamp, apply signs, force (1,0,0) for coincident points
  logic [2:0][NrmW-1:0] nrm_d;

  always_comb begin
    logic [QW-1:0]   qc;
    logic [NrmW-1:0] qe;
    for (int i = 0; i < 3; i++) begin
      qc = (dq_q[DvSteps-1][i] > OneQ14) ? OneQ14 : dq_q[DvSteps-1][i];
      qe = NrmW'(qc);
      nrm_d[i] = carry_q[StQnt-1].sgn[i] ? -qe : qe;
    end
    if (carry_q[StQnt-1].zedge) begin
      nrm_d[0] = NrmW'(OneQ14);
      nrm_d[1] = '0;
      nrm_d[2] = '0;
    end
  end

  // Side data: copy forward, fill in where it becomes known
  always_comb begin
    carry_d[0]       = '0;
    carry_d[0].sum   = sum0;
    for (int k = 1; k < NSt; k++) begin
      carry_d[k] = carry_q[k-1];
    end
    carry_d[StPick].deg  = zero3;
    carry_d[StSel].zedge = zedge4;
    carry_d[StSel].sgn   = sgn4;
    carry_d[StQnt].nrm   = nrm_d;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSt; k++) begin
      if (en[k]) carry_q[k] <= carry_d[k];
    end
  end

  // Offset: centroid sums times normal
  logic signed [PrdW-1:0] pd_d [3], pd_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_d[i] = $signed(carry_q[StQnt].sum[i]) * $signed(carry_q[StQnt].nrm[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StDotm]) pd_q <= pd_d;
  end

  // Negated dot product
  logic signed [DotW-1:0] dot_q;

  always_ff @(posedge clk_i) begin
    if (en[StDots]) begin
      dot_q <= -(DotW'(pd_q[0]) + DotW'(pd_q[1]) + DotW'(pd_q[2]));
    end
  end

  // Round: add half of 49152, drop the power-of-two part
  logic [TW-1:0] t_d, t_q;
  logic          neg_q;

  always_comb begin
    logic [DotW-1:0] mag;
    mag = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
    mag = mag + OffHalf;
    t_d = mag[14 +: TW];
  end

  always_ff @(posedge clk_i) begin
    if (en[StRnd]) begin
      t_q   <= t_d;
      neg_q <= dot_q[DotW-1];
    end
  end

  // Divide by three through the reciprocal
  logic [QqW-1:0] qq_q;
  logic           neg3_q;

  logic [TW+TW:0] prd3;
  assign prd3 = t_q * Recip3;

  always_ff @(posedge clk_i) begin
    if (en[StDiv3]) begin
      qq_q   <= prd3[21 +: QqW];
      neg3_q <= neg_q;
    end
  end

  // Saturate and sign
  logic [OffW-1:0] off_d, off_q;

  always_comb begin
    logic [OffW-1:0] qe;
    qe = OffW'(qq_q);
    if (neg3_q) begin
      off_d = (qq_q > OffNegMax) ? -OffW'(OffNegMax) : -qe;
    end else begin
      off_d = (qq_q > OffPosMax) ? OffW'(OffPosMax) : qe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) off_q <= off_d;
  end

  // Output beat
  assign m_axis_tvalid_o = vld_q[StOut];
  assign m_axis_tdata_o  = {(OutDataW - 3*NrmW - OffW)'(0), off_q,
                            carry_q[StOut].nrm[2], carry_q[StOut].nrm[1],
                            carry_q[StOut].nrm[0]};
  assign m_axis_tuser_o  = carry_q[StOut].deg;

endmodule
